// ----- src/rybpcb_pkg.sv -----
// shared types and default constants for the ryb pigment color blend
`default_nettype none

package rybpcb_pkg;

   localparam int FRAC_BITS_DEF   = 16;
   localparam int WEIGHT_BITS_DEF = 10;
   localparam int CHAN_W          = 8;
   localparam int WEIGHT_FIELD_W  = 10;

   typedef struct packed {
      logic [CHAN_W-1:0]         a_red;
      logic [CHAN_W-1:0]         a_green;
      logic [CHAN_W-1:0]         a_blue;
      logic [CHAN_W-1:0]         b_red;
      logic [CHAN_W-1:0]         b_green;
      logic [CHAN_W-1:0]         b_blue;
      logic [WEIGHT_FIELD_W-1:0] weight_a;
      logic [WEIGHT_FIELD_W-1:0] weight_b;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] mix_red;
      logic [CHAN_W-1:0] mix_green;
      logic [CHAN_W-1:0] mix_blue;
   } rsp_type;

endpackage

`default_nettype wire

// ----- src/rybpcb_div.sv -----
// pipelined restoring divider, one quotient bit per stage, several lanes
`default_nettype none

module rybpcb_div #(
   parameter int LANES  = 1,
   parameter int DEN_W  = 12,
   parameter int QUO_W  = 11,
   parameter int SIDE_W = 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 in_valid,
   input  logic [LANES-1:0][DEN_W+QUO_W-1:0]    in_num,
   input  logic [LANES-1:0][DEN_W-1:0]          in_den,
   input  logic [SIDE_W-1:0]                    in_side,
   output logic                                 out_valid,
   output logic [LANES-1:0][QUO_W-1:0]          out_quo,
   output logic [SIDE_W-1:0]                    out_side
);

   localparam int NUM_W = DEN_W + QUO_W;

   logic [QUO_W-1:0]                 vld_ff;
   logic [LANES-1:0][DEN_W-1:0]      rem_ff  [QUO_W];
   logic [LANES-1:0][DEN_W-1:0]      den_ff  [QUO_W];
   logic [LANES-1:0][QUO_W-1:0]      sh_ff   [QUO_W];
   logic [SIDE_W-1:0]                side_ff [QUO_W];

   genvar k, ln;
   for (k = 0; k < QUO_W; k++) begin : g_stage
      logic                        vld_src;
      logic [LANES-1:0][DEN_W-1:0] rem_src;
      logic [LANES-1:0][DEN_W-1:0] den_src;
      logic [LANES-1:0][QUO_W-1:0] sh_src;
      logic [SIDE_W-1:0]           side_src;
      logic [LANES-1:0][DEN_W-1:0] rem_in;
      logic [LANES-1:0][QUO_W-1:0] sh_in;

      if (k == 0) begin : g_first
         // quotient fits in QUO_W bits, so the upper numerator part is below the divisor
         assign vld_src  = in_valid;
         assign den_src  = in_den;
         assign side_src = in_side;
         for (ln = 0; ln < LANES; ln++) begin : g_split
            assign rem_src[ln] = in_num[ln][NUM_W-1:QUO_W];
            assign sh_src[ln]  = in_num[ln][QUO_W-1:0];
         end
      end else begin : g_next
         assign vld_src  = vld_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign den_src  = den_ff[k-1];
         assign sh_src   = sh_ff[k-1];
         assign side_src = side_ff[k-1];
      end

      always_comb begin
         logic [DEN_W:0] trial;
         logic           fits;
         rem_in = rem_src;
         sh_in  = sh_src;
         for (int i = 0; i < LANES; i++) begin
            trial     = {rem_src[i], sh_src[i][QUO_W-1]};
            fits      = trial >= {1'b0, den_src[i]};
            rem_in[i] = fits ? DEN_W'(trial - {1'b0, den_src[i]}) : trial[DEN_W-1:0];
            sh_in[i]  = {sh_src[i][QUO_W-2:0], fits};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            den_ff[k]  <= den_src;
            sh_ff[k]   <= sh_in;
            side_ff[k] <= side_src;
         end
      end
   end

   assign out_valid = vld_ff[QUO_W-1];
   assign out_quo   = sh_ff[QUO_W-1];
   assign out_side  = side_ff[QUO_W-1];

endmodule

`default_nettype wire

// ----- src/ryb_pigment_color_blend.sv -----
// top level of the ryb pigment color blend pipeline
//
//   channel   direction   handshake              payload
//   req       in          req_valid/req_stall    req_data  (two rgb colors, two weights)
//   rsp       out         rsp_valid/rsp_stall    rsp_data  (blended rgb color)
//
// one beat is taken every cycle while req_stall is low
// the pipeline holds three bit-per-stage dividers of FRAC_BITS+1 stages each
// reset is synchronous and clears only the valid bits
// the whole pipeline advances together; a one-entry skid behind the output
// register catches the beat in flight when rsp_stall rises, then req_stall goes high
`default_nettype none

module ryb_pigment_color_blend
   import rybpcb_pkg::*;
#(
   parameter int FRAC_BITS   = FRAC_BITS_DEF,
   parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int VW = FRAC_BITS + 1;
   localparam int XW = FRAC_BITS + 2;
   localparam int WU = (WEIGHT_BITS < WEIGHT_FIELD_W) ? WEIGHT_BITS : WEIGHT_FIELD_W;
   localparam int TW = WU + 1;
   localparam int DW = XW;
   localparam int QW = VW;
   localparam int NW = DW + QW;
   localparam int PW = 2 * VW;

   localparam logic [VW-1:0] ONE_V  = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [VW-1:0] HALF_V = ONE_V >> 1;
   localparam logic [63:0]   EPS_L  = (64'd1 << FRAC_BITS) / 64'd1000000;
   localparam logic [VW-1:0] EPS_V  = EPS_L[VW-1:0];

   typedef logic [2:0][VW-1:0] tri_v_type;
   typedef logic [2:0][XW-1:0] tri_x_type;

   typedef struct packed {
      logic [1:0][VW-1:0] w;
      tri_v_type [1:0]    x;
      logic [1:0]         ok;
      logic [1:0][VW-1:0] mx;
      logic               tz;
   } side1_type;

   typedef struct packed {
      logic [VW-1:0] w;
      tri_x_type     x;
      logic          ok;
      logic [VW-1:0] vt;
   } side2_type;

   typedef struct packed {
      tri_v_type res;
      logic      ok;
   } side3_type;

   function automatic logic [VW-1:0] min3v(input logic [VW-1:0] a, b, c);
      logic [VW-1:0] m;
      m = (a < b) ? a : b;
      return (m < c) ? m : c;
   endfunction

   function automatic logic [VW-1:0] max3v(input logic [VW-1:0] a, b, c);
      logic [VW-1:0] m;
      m = (a > b) ? a : b;
      return (m > c) ? m : c;
   endfunction

   function automatic logic [XW-1:0] max3x(input logic [XW-1:0] a, b, c);
      logic [XW-1:0] m;
      m = (a > b) ? a : b;
      return (m > c) ? m : c;
   endfunction

   function automatic logic [VW-1:0] sat_v(input logic [XW:0] x);
      return (x > (XW+1)'(ONE_V)) ? ONE_V : x[VW-1:0];
   endfunction

   // 8-bit code to fixed point, rounded: (c*ONE + 127) / 255
   logic [VW-1:0] u8_lut [256];
   genvar gi;
   for (gi = 0; gi < 256; gi++) begin : g_lut
      localparam logic [63:0] LV = ((64'(gi) << FRAC_BITS) + 64'd127) / 64'd255;
      assign u8_lut[gi] = LV[VW-1:0];
   end

   logic en;

   // valid bits of the top-level stages
   logic [5:1]   va_ff, va_in;
   logic [12:6]  vb_ff, vb_in;
   logic [15:13] vc_ff, vc_in;
   logic         d1_vld, d2_vld, d3_vld;

   assign va_in = {va_ff[4:1], req_valid};
   assign vb_in = {vb_ff[11:6], d1_vld};
   assign vc_in = {vc_ff[14:13], d2_vld};

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= '0;
         vb_ff <= '0;
         vc_ff <= '0;
      end else if (en) begin
         va_ff <= va_in;
         vb_ff <= vb_in;
         vc_ff <= vc_in;
      end
   end

   // ---------------- stage 1: convert to fixed point
   tri_v_type [1:0] col1_ff, col1_in;
   logic [WU-1:0]   wa1_ff, wa1_in, wb1_ff, wb1_in;

   always_comb begin
      col1_in[0][0] = u8_lut[req_data.a_red];
      col1_in[0][1] = u8_lut[req_data.a_green];
      col1_in[0][2] = u8_lut[req_data.a_blue];
      col1_in[1][0] = u8_lut[req_data.b_red];
      col1_in[1][1] = u8_lut[req_data.b_green];
      col1_in[1][2] = u8_lut[req_data.b_blue];
      wa1_in        = req_data.weight_a[WU-1:0];
      wb1_in        = req_data.weight_b[WU-1:0];
   end

   // ---------------- stage 2: remove white
   logic [1:0][VW-1:0] w2_ff, w2_in, mx2_ff, mx2_in;
   tri_v_type [1:0]    d2_ff, d2_in;
   logic [WU-1:0]      wa2_ff, wa2_in;
   logic [TW-1:0]      tot2_ff, tot2_in;

   always_comb begin
      for (int c = 0; c < 2; c++) begin
         w2_in[c]  = min3v(col1_ff[c][0], col1_ff[c][1], col1_ff[c][2]);
         mx2_in[c] = max3v(col1_ff[c][0], col1_ff[c][1], col1_ff[c][2]);
         for (int k = 0; k < 3; k++) begin
            d2_in[c][k] = col1_ff[c][k] - w2_in[c];
         end
      end
      wa2_in  = wa1_ff;
      tot2_in = TW'(wa1_ff) + TW'(wb1_ff);
   end

   // ---------------- stage 3: peak, yellow from red and green
   logic [1:0][VW-1:0] w3_ff, w3_in, pk3_ff, pk3_in, mx3_ff, mx3_in;
   logic [1:0][VW-1:0] r3_ff, r3_in, y3_ff, y3_in, g3_ff, g3_in, b3_ff, b3_in;
   logic [WU-1:0]      wa3_ff;
   logic [TW-1:0]      tot3_ff;

   always_comb begin
      for (int c = 0; c < 2; c++) begin
         pk3_in[c] = max3v(d2_ff[c][0], d2_ff[c][1], d2_ff[c][2]);
         y3_in[c]  = (d2_ff[c][0] < d2_ff[c][1]) ? d2_ff[c][0] : d2_ff[c][1];
         r3_in[c]  = d2_ff[c][0] - y3_in[c];
         g3_in[c]  = d2_ff[c][1] - y3_in[c];
         b3_in[c]  = d2_ff[c][2];
         w3_in[c]  = w2_ff[c];
         mx3_in[c] = mx2_ff[c];
      end
   end

   // ---------------- stage 4: split green, find renormalize target
   logic [1:0][VW-1:0] w4_ff, w4_in, pk4_ff, pk4_in, mx4_ff, mx4_in, tg4_ff, tg4_in;
   logic [1:0][VW-1:0] r4_ff, r4_in, y4_ff, y4_in, b4_ff, b4_in;
   logic [WU-1:0]      wa4_ff;
   logic [TW-1:0]      tot4_ff;

   always_comb begin
      logic          hv;
      logic [VW-1:0] bh, gh;
      for (int c = 0; c < 2; c++) begin
         hv        = (b3_ff[c] != '0) && (g3_ff[c] != '0);
         bh        = hv ? (b3_ff[c] >> 1) : b3_ff[c];
         gh        = hv ? (g3_ff[c] >> 1) : g3_ff[c];
         y4_in[c]  = y3_ff[c] + gh;
         b4_in[c]  = bh + gh;
         r4_in[c]  = r3_ff[c];
         tg4_in[c] = max3v(r3_ff[c], y4_in[c], b4_in[c]);
         w4_in[c]  = w3_ff[c];
         pk4_in[c] = pk3_ff[c];
         mx4_in[c] = mx3_ff[c];
      end
   end

   // ---------------- stage 5: ratio numerators for the first divider
   logic [6:0][NW-1:0] num5_ff, num5_in;
   logic [6:0][DW-1:0] den5_ff, den5_in;
   side1_type          sd5_ff, sd5_in;

   always_comb begin
      logic [PW-1:0] p;
      tri_v_type     x;
      for (int c = 0; c < 2; c++) begin
         x[0] = r4_ff[c];
         x[1] = y4_ff[c];
         x[2] = b4_ff[c];
         for (int k = 0; k < 3; k++) begin
            p                 = x[k] * pk4_ff[c];
            num5_in[c*3 + k]  = NW'(p) + NW'(tg4_ff[c] >> 1);
            den5_in[c*3 + k]  = DW'(tg4_ff[c]);
         end
         sd5_in.w[c]  = w4_ff[c];
         sd5_in.x[c]  = x;
         sd5_in.ok[c] = tg4_ff[c] > EPS_V;
         sd5_in.mx[c] = mx4_ff[c];
      end
      num5_in[6] = NW'({wa4_ff, {FRAC_BITS{1'b0}}}) + NW'(tot4_ff >> 1);
      den5_in[6] = DW'(tot4_ff);
      sd5_in.tz  = (tot4_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         col1_ff <= col1_in;
         wa1_ff  <= wa1_in;
         wb1_ff  <= wb1_in;
         w2_ff   <= w2_in;
         mx2_ff  <= mx2_in;
         d2_ff   <= d2_in;
         wa2_ff  <= wa2_in;
         tot2_ff <= tot2_in;
         w3_ff   <= w3_in;
         pk3_ff  <= pk3_in;
         mx3_ff  <= mx3_in;
         r3_ff   <= r3_in;
         y3_ff   <= y3_in;
         g3_ff   <= g3_in;
         b3_ff   <= b3_in;
         wa3_ff  <= wa2_ff;
         tot3_ff <= tot2_ff;
         w4_ff   <= w4_in;
         pk4_ff  <= pk4_in;
         mx4_ff  <= mx4_in;
         tg4_ff  <= tg4_in;
         r4_ff   <= r4_in;
         y4_ff   <= y4_in;
         b4_ff   <= b4_in;
         wa4_ff  <= wa3_ff;
         tot4_ff <= tot3_ff;
         num5_ff <= num5_in;
         den5_ff <= den5_in;
         sd5_ff  <= sd5_in;
      end
   end

   logic [6:0][QW-1:0] q1;
   side1_type          sd1;

   rybpcb_div #(
      .LANES  (7),
      .DEN_W  (DW),
      .QUO_W  (QW),
      .SIDE_W ($bits(side1_type))
   ) u_div_in (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (va_ff[5]),
      .in_num    (num5_ff),
      .in_den    (den5_ff),
      .in_side   (sd5_ff),
      .out_valid (d1_vld),
      .out_quo   (q1),
      .out_side  (sd1)
   );

   // ---------------- stage 6: finish pigment conversion, weights
   tri_v_type [1:0]    pg6_ff, pg6_in;
   logic [VW-1:0]      wa6_ff, wa6_in, wb6_ff, wb6_in;
   logic [1:0][VW-1:0] mx6_ff, mx6_in;

   always_comb begin
      logic [VW-1:0] x;
      for (int c = 0; c < 2; c++) begin
         for (int k = 0; k < 3; k++) begin
            x            = sd1.ok[c] ? q1[c*3 + k] : sd1.x[c][k];
            pg6_in[c][k] = sat_v((XW+1)'(x) + (XW+1)'(sd1.w[c]));
         end
      end
      wa6_in = sd1.tz ? HALF_V : q1[6];
      wb6_in = ONE_V - wa6_in;
      mx6_in = sd1.mx;
   end

   // ---------------- stage 7: weighted products (index 3 is the peak)
   logic [3:0][PW-1:0] pa7_ff, pa7_in, pb7_ff, pb7_in;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         pa7_in[k] = wa6_ff * pg6_ff[0][k];
         pb7_in[k] = wb6_ff * pg6_ff[1][k];
      end
      pa7_in[3] = wa6_ff * mx6_ff[0];
      pb7_in[3] = wb6_ff * mx6_ff[1];
   end

   // ---------------- stage 8: blend sums
   logic [3:0][VW-1:0] mx8_ff, mx8_in;

   always_comb begin
      logic [PW:0] s;
      for (int k = 0; k < 4; k++) begin
         s         = (PW+1)'(pa7_ff[k]) + (PW+1)'(pb7_ff[k]) + (PW+1)'(HALF_V);
         mx8_in[k] = s[2*FRAC_BITS:FRAC_BITS];
      end
   end

   // ---------------- stage 9: back to rgb, remove white
   logic [VW-1:0] w9_ff, w9_in, vt9_ff;
   tri_v_type     d9_ff, d9_in;

   always_comb begin
      w9_in = min3v(mx8_ff[0], mx8_ff[1], mx8_ff[2]);
      for (int k = 0; k < 3; k++) begin
         d9_in[k] = mx8_ff[k] - w9_in;
      end
   end

   // ---------------- stage 10: peak, green from yellow and blue
   logic [VW-1:0] w10_ff, pk10_ff, pk10_in, vt10_ff;
   logic [VW-1:0] r10_ff, y10_ff, y10_in, g10_ff, g10_in, b10_ff, b10_in;

   always_comb begin
      pk10_in = max3v(d9_ff[0], d9_ff[1], d9_ff[2]);
      g10_in  = (d9_ff[1] < d9_ff[2]) ? d9_ff[1] : d9_ff[2];
      y10_in  = d9_ff[1] - g10_in;
      b10_in  = d9_ff[2] - g10_in;
   end

   // ---------------- stage 11: restore green, current peak
   logic [VW-1:0] w11_ff, pk11_ff, vt11_ff;
   tri_x_type     x11_ff, x11_in;
   logic [XW-1:0] cur11_ff, cur11_in;

   always_comb begin
      logic          dbl;
      logic [XW-1:0] gx;
      dbl       = (b10_ff != '0) && (g10_ff != '0);
      gx        = dbl ? {g10_ff, 1'b0} : XW'(g10_ff);
      x11_in[0] = XW'(r10_ff) + XW'(y10_ff);
      x11_in[1] = gx + XW'(y10_ff);
      x11_in[2] = dbl ? {b10_ff, 1'b0} : XW'(b10_ff);
      cur11_in  = max3x(x11_in[0], x11_in[1], x11_in[2]);
   end

   // ---------------- stage 12: ratio numerators for the second divider
   logic [2:0][NW-1:0] num12_ff, num12_in;
   logic [DW-1:0]      den12_ff;
   side2_type          sd12_ff, sd12_in;

   always_comb begin
      logic [XW+VW-1:0] p;
      for (int k = 0; k < 3; k++) begin
         p           = x11_ff[k] * pk11_ff;
         num12_in[k] = NW'(p) + NW'(cur11_ff >> 1);
      end
      sd12_in.w  = w11_ff;
      sd12_in.x  = x11_ff;
      sd12_in.ok = cur11_ff > XW'(EPS_V);
      sd12_in.vt = vt11_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pg6_ff   <= pg6_in;
         wa6_ff   <= wa6_in;
         wb6_ff   <= wb6_in;
         mx6_ff   <= mx6_in;
         pa7_ff   <= pa7_in;
         pb7_ff   <= pb7_in;
         mx8_ff   <= mx8_in;
         w9_ff    <= w9_in;
         d9_ff    <= d9_in;
         vt9_ff   <= mx8_ff[3];
         w10_ff   <= w9_ff;
         pk10_ff  <= pk10_in;
         vt10_ff  <= vt9_ff;
         r10_ff   <= d9_ff[0];
         y10_ff   <= y10_in;
         g10_ff   <= g10_in;
         b10_ff   <= b10_in;
         w11_ff   <= w10_ff;
         pk11_ff  <= pk10_ff;
         vt11_ff  <= vt10_ff;
         x11_ff   <= x11_in;
         cur11_ff <= cur11_in;
         num12_ff <= num12_in;
         den12_ff <= cur11_ff;
         sd12_ff  <= sd12_in;
      end
   end

   logic [2:0][QW-1:0] q2;
   side2_type          sd2;

   rybpcb_div #(
      .LANES  (3),
      .DEN_W  (DW),
      .QUO_W  (QW),
      .SIDE_W ($bits(side2_type))
   ) u_div_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vb_ff[12]),
      .in_num    (num12_ff),
      .in_den    ({3{den12_ff}}),
      .in_side   (sd12_ff),
      .out_valid (d2_vld),
      .out_quo   (q2),
      .out_side  (sd2)
   );

   // ---------------- stage 13: finish rgb conversion
   tri_v_type     res13_ff, res13_in;
   logic [VW-1:0] vt13_ff;

   always_comb begin
      logic [XW-1:0] x;
      for (int k = 0; k < 3; k++) begin
         x           = sd2.ok ? XW'(q2[k]) : sd2.x[k];
         res13_in[k] = sat_v((XW+1)'(x) + (XW+1)'(sd2.w));
      end
   end

   // ---------------- stage 14: brightness check
   tri_v_type     res14_ff;
   logic [VW-1:0] vo14_ff, vo14_in, vt14_ff;
   logic          ok14_ff, ok14_in;

   always_comb begin
      vo14_in = max3v(res13_ff[0], res13_ff[1], res13_ff[2]);
      ok14_in = (vo14_in > EPS_V) && (vt13_ff != '0);
   end

   // ---------------- stage 15: numerators for the brightness rescale
   logic [2:0][NW-1:0] num15_ff, num15_in;
   logic [DW-1:0]      den15_ff;
   side3_type          sd15_ff, sd15_in;

   always_comb begin
      logic [PW-1:0] p;
      for (int k = 0; k < 3; k++) begin
         p           = res14_ff[k] * vt14_ff;
         num15_in[k] = NW'(p) + NW'(vo14_ff >> 1);
      end
      sd15_in.res = res14_ff;
      sd15_in.ok  = ok14_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res13_ff <= res13_in;
         vt13_ff  <= sd2.vt;
         res14_ff <= res13_ff;
         vo14_ff  <= vo14_in;
         vt14_ff  <= vt13_ff;
         ok14_ff  <= ok14_in;
         num15_ff <= num15_in;
         den15_ff <= DW'(vo14_ff);
         sd15_ff  <= sd15_in;
      end
   end

   logic [2:0][QW-1:0] q3;
   side3_type          sd3;

   rybpcb_div #(
      .LANES  (3),
      .DEN_W  (DW),
      .QUO_W  (QW),
      .SIDE_W ($bits(side3_type))
   ) u_div_scale (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vc_ff[15]),
      .in_num    (num15_ff),
      .in_den    ({3{den15_ff}}),
      .in_side   (sd15_ff),
      .out_valid (d3_vld),
      .out_quo   (q3),
      .out_side  (sd3)
   );

   // ---------------- stage 16: select, clamp and round to 8 bits
   logic [2:0][CHAN_W-1:0] c8;
   rsp_type                mix16;

   always_comb begin
      logic [VW-1:0]   v;
      logic [VW+7:0]   t;
      for (int k = 0; k < 3; k++) begin
         v     = sat_v((XW+1)'(sd3.ok ? q3[k] : sd3.res[k]));
         t     = {v, 8'h00} - (VW+8)'(v) + (VW+8)'(HALF_V);
         c8[k] = t[FRAC_BITS+7:FRAC_BITS];
      end
      mix16.mix_red   = c8[0];
      mix16.mix_green = c8[1];
      mix16.mix_blue  = c8[2];
   end

   // ---------------- output register and skid
   logic    rsp_valid_ff, rsp_valid_in, skid_valid_ff, skid_valid_in;
   rsp_type rsp_data_ff, rsp_data_in, skid_data_ff, skid_data_in;
   logic    rsp_take, new_beat;

   assign en        = ~skid_valid_ff;
   assign req_stall = skid_valid_ff;

   assign rsp_take = rsp_valid_ff & ~rsp_stall;
   assign new_beat = en & d3_vld;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (rsp_take) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (new_beat) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_data_in  = mix16;
            rsp_valid_in = 1'b1;
         end else begin
            skid_data_in  = mix16;
            skid_valid_in = 1'b1;
         end
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // skid only holds a beat behind a waiting output beat
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid full while output empty");

   a_skid_fill_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_valid_ff && rsp_stall))
      else $error("skid filled without a stalled output");

   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_stall) |=> (rsp_valid_ff && !skid_valid_ff))
      else $error("skid beat not moved to output");

endmodule

`default_nettype wire
